/* sv/stra_pkg.sv */
// ----------------------------------------------------------------------------
// stra_pkg: shared types for the segment tree range-add / point-query core
// Field types, microcode step codes and the control store of the sequencer.
// ----------------------------------------------------------------------------
package stra_pkg;

	localparam int IDX_W = 10;
	localparam int CNT_W = 16;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic signed [CNT_W-1:0] cnt_t;

	// func field codes
	localparam logic FN_ADD   = 1'b0;
	localparam logic FN_QUERY = 1'b1;

	// Microcode steps (program counter values)
	typedef enum logic [2:0] {
		ST_CLR,    // clearing pass, one node per cycle
		ST_IDLE,   // wait for a command beat, dispatch
		ST_AX,     // range add: loop test, read node l
		ST_AY,     // range add: write node l if odd, read node r-1
		ST_AZ,     // range add: write node r-1 if r odd, climb one level
		ST_QR,     // point query: read node n
		ST_QA,     // point query: accumulate, climb one level
		ST_OUT     // load the result register
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEXT,      // never jump
		C_ALWAYS,    // always jump
		C_DISPATCH,  // command beat taken, target from decode
		C_CLR_END,   // last node cleared
		C_L_GE_R,    // range walk finished
		C_N_MORE,    // parent of n is a real node
		C_OUT_FREE   // result register can take a value
	} cond_t;

	// Read address select
	typedef enum logic {
		RA_L,
		RA_RM1
	} rsel_t;

	// Write select
	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLR,
		WR_L_ODD,
		WR_R_ODD
	} wsel_t;

	// Register update action
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CNT,
		ACT_STEP_L,
		ACT_SHIFT,
		ACT_ACC,
		ACT_OUT
	} act_t;

	// One control word
	typedef struct packed {
		cond_t cond;
		logic  hold;     // stay on this step when the condition is false
		step_t target;
		rsel_t rsel;
		wsel_t wsel;
		act_t  act;
	} uword_t;

	// Control store
	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '{cond: C_NEXT, hold: 1'b0, target: ST_IDLE, rsel: RA_L,
			wsel: WR_NONE, act: ACT_NONE};
		case (s)
			ST_CLR: begin
				w = '{cond: C_CLR_END, hold: 1'b1, target: ST_IDLE, rsel: RA_L,
					wsel: WR_CLR, act: ACT_CNT};
			end
			ST_IDLE: begin
				w = '{cond: C_DISPATCH, hold: 1'b1, target: ST_IDLE, rsel: RA_L,
					wsel: WR_NONE, act: ACT_NONE};
			end
			ST_AX: begin
				w = '{cond: C_L_GE_R, hold: 1'b0, target: ST_IDLE, rsel: RA_L,
					wsel: WR_NONE, act: ACT_NONE};
			end
			ST_AY: begin
				w = '{cond: C_NEXT, hold: 1'b0, target: ST_IDLE, rsel: RA_RM1,
					wsel: WR_L_ODD, act: ACT_STEP_L};
			end
			ST_AZ: begin
				w = '{cond: C_ALWAYS, hold: 1'b0, target: ST_AX, rsel: RA_L,
					wsel: WR_R_ODD, act: ACT_SHIFT};
			end
			ST_QR: begin
				w = '{cond: C_NEXT, hold: 1'b0, target: ST_IDLE, rsel: RA_L,
					wsel: WR_NONE, act: ACT_NONE};
			end
			ST_QA: begin
				w = '{cond: C_N_MORE, hold: 1'b0, target: ST_QR, rsel: RA_L,
					wsel: WR_NONE, act: ACT_ACC};
			end
			ST_OUT: begin
				w = '{cond: C_OUT_FREE, hold: 1'b1, target: ST_IDLE, rsel: RA_L,
					wsel: WR_NONE, act: ACT_OUT};
			end
			default: begin
				w = '{cond: C_ALWAYS, hold: 1'b0, target: ST_IDLE, rsel: RA_L,
					wsel: WR_NONE, act: ACT_NONE};
			end
		endcase
		return w;
	endfunction

endpackage

/* sv/stra_cmd_if.sv */
// ----------------------------------------------------------------------------
// stra_cmd_if: command channel
// Valid/ready channel carrying one range-add or point-query command per beat.
// ----------------------------------------------------------------------------
interface stra_cmd_if;

	logic             valid;
	logic             ready;
	logic             func;
	stra_pkg::idx_t   low_index;
	stra_pkg::idx_t   high_index;
	stra_pkg::cnt_t   delta;

	modport source(output valid, output func, output low_index, output high_index,
		output delta, input ready);
	modport sink(input valid, input func, input low_index, input high_index,
		input delta, output ready);

endinterface

/* sv/stra_rsp_if.sv */
// ----------------------------------------------------------------------------
// stra_rsp_if: result channel
// Valid/ready channel carrying one point total per beat.
// ----------------------------------------------------------------------------
interface stra_rsp_if;

	logic             valid;
	logic             ready;
	stra_pkg::cnt_t   point_total;

	modport source(output valid, output point_total, input ready);
	modport sink(input valid, input point_total, output ready);

endinterface

/* sv/segment_tree_range_add_point_query_core.sv */
// ----------------------------------------------------------------------------
// segment_tree_range_add_point_query_core: microcoded segment tree engine
// Range add over an inclusive index range, point query of one position.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries func, low_index, high_index, delta. func = add walks the
//   bottom-up tree and adds delta to each node covering the range; an empty,
//   reversed or out-of-tree range changes nothing. func = query sums the
//   counts from the leaf up to the root and sends one point_total beat on
//   rsp (0 for a position beyond the tree). Adds send nothing.
//   One command is in work at a time; cmd.ready is high only while the
//   sequencer waits for a command.
//   A query waits while the result register is full. Each node visit is a
//   registered read from the single node memory followed by a write or an
//   accumulate.
//   Reset: a clearing pass zeroes all 2*POSITIONS nodes, one per cycle;
//   cmd.ready stays low until the pass is done.
//   A stalled rsp holds its beat in the result register; the core still
//   takes the next command and only halts when a second total is ready.
// ----------------------------------------------------------------------------
module segment_tree_range_add_point_query_core #(
	parameter int POSITIONS = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	stra_cmd_if.sink   cmd,
	stra_rsp_if.source rsp
);
	import stra_pkg::*;

	localparam int NODES = 2 * POSITIONS;
	localparam int AW    = $clog2(NODES);
	localparam int LW    = AW + 1;
	localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
	localparam logic [31:0]   POS32     = 32'(POSITIONS);

	// sequencer
	step_t  upc_q, upc_d;
	uword_t uw;
	logic   hit;
	step_t  disp_tgt;

	// datapath
	logic [LW-1:0]    l_q, r_q, rm1;
	cnt_t             acc_q, delta_q, total_q;
	logic             out_valid_q, out_free;
	logic [CNT_W-1:0] node_mem [NODES];
	logic [CNT_W-1:0] rd_q, wd;
	logic [AW-1:0]    ra, wa;
	logic             we;

	// command decode
	logic        accept;
	logic [31:0] lo_w, hi_w;
	logic        add_ok, q_ok;

	assign uw       = ucode(upc_q);
	assign cmd.ready = (upc_q == ST_IDLE);
	assign accept   = cmd.valid && cmd.ready;
	assign lo_w     = 32'(cmd.low_index);
	assign hi_w     = 32'(cmd.high_index);
	assign add_ok   = (lo_w <= hi_w) && (hi_w < POS32);
	assign q_ok     = (lo_w < POS32);
	assign out_free = !out_valid_q || rsp.ready;
	assign rm1      = r_q - LW'(1);

	// dispatch target for an accepted command
	always_comb begin
		if (cmd.func == FN_QUERY) begin
			disp_tgt = q_ok ? ST_QR : ST_OUT;
		end else begin
			disp_tgt = add_ok ? ST_AX : ST_IDLE;
		end
	end

	// condition evaluation and next step
	always_comb begin
		case (uw.cond)
			C_NEXT:     hit = 1'b0;
			C_ALWAYS:   hit = 1'b1;
			C_DISPATCH: hit = accept;
			C_CLR_END:  hit = (l_q[AW-1:0] == LAST_NODE);
			C_L_GE_R:   hit = !(l_q < r_q);
			C_N_MORE:   hit = (l_q[LW-1:1] != '0);
			C_OUT_FREE: hit = out_free;
			default:    hit = 1'b1;
		endcase
		if (hit) begin
			upc_d = (uw.cond == C_DISPATCH) ? disp_tgt : uw.target;
		end else if (uw.hold) begin
			upc_d = upc_q;
		end else begin
			upc_d = step_t'(upc_q + 3'd1);
		end
	end

	// memory port controls from the control word
	always_comb begin
		ra = (uw.rsel == RA_RM1) ? rm1[AW-1:0] : l_q[AW-1:0];
		wd = rd_q + $unsigned(delta_q);
		case (uw.wsel)
			WR_CLR: begin
				we = 1'b1;
				wa = l_q[AW-1:0];
				wd = '0;
			end
			WR_L_ODD: begin
				we = l_q[0];
				wa = l_q[AW-1:0];
			end
			WR_R_ODD: begin
				we = r_q[0];
				wa = rm1[AW-1:0];
			end
			default: begin
				we = 1'b0;
				wa = l_q[AW-1:0];
			end
		endcase
	end

	// node memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			node_mem[wa] <= wd;
		end
		rd_q <= node_mem[ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= ST_CLR;
			l_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			// walk index: clear counter, l cursor, or query node
			if (accept) begin
				l_q <= LW'(lo_w + POS32);
			end else begin
				case (uw.act)
					ACT_CNT:    l_q <= l_q + LW'(1);
					ACT_STEP_L: l_q <= l_q + LW'(l_q[0]);
					ACT_SHIFT:  l_q <= l_q >> 1;
					ACT_ACC:    l_q <= l_q >> 1;
					default:    l_q <= l_q;
				endcase
			end
			// result register
			if (uw.act == ACT_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			r_q     <= LW'(hi_w + POS32 + 32'd1);
			acc_q   <= '0;
			delta_q <= cmd.delta;
		end else begin
			if (uw.act == ACT_SHIFT) begin
				r_q <= r_q >> 1;
			end
			if (uw.act == ACT_ACC) begin
				acc_q <= acc_q + $signed(rd_q);
			end
		end
		if (uw.act == ACT_OUT && out_free) begin
			total_q <= acc_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.point_total = total_q;

endmodule

/* sv/stra_checker.sv */
// ----------------------------------------------------------------------------
// stra_checker: port-level checks for the segment tree core
// Tracks outstanding queries and checks result beats against them and channel rules.
// ----------------------------------------------------------------------------
module stra_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_ready,
	input  logic           cmd_func,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  stra_pkg::cnt_t rsp_point_total
);
	import stra_pkg::*;

	logic       cmd_beat, rsp_beat, q_beat;
	logic [1:0] pend_q;

	assign cmd_beat = cmd_valid && cmd_ready;
	assign rsp_beat = rsp_valid && rsp_ready;
	assign q_beat   = cmd_beat && (cmd_func == FN_QUERY);

	// queries accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (q_beat && !rsp_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_beat && !q_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// a total is only shown for an outstanding query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0))
		else $error("result beat with no outstanding query");

	// at most one total held plus one in work
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many outstanding queries");

	// a query blocks the command channel while it walks the tree
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_beat |=> !cmd_ready)
		else $error("command taken during a query walk");

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_total))
		else $error("stalled result beat changed");

endmodule

bind segment_tree_range_add_point_query_core stra_checker u_stra_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.cmd_func        (cmd.func),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_point_total (rsp.point_total)
);

/* sim/segment_tree_range_add_point_query_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_tree_range_add_point_query_core_test: self-checking bench
// Drives range-add and point-query beats into the core with random idling on
// both channels. A behavioral copy of the bottom-up tree predicts each point
// total, and every result beat is compared in order against that prediction.
// ----------------------------------------------------------------------------
module segment_tree_range_add_point_query_core_test;

	import stra_pkg::*;

	localparam int     POSITIONS   = 1024;
	localparam int     NODES       = 2 * POSITIONS;
	localparam idx_t   IDX_MAX     = idx_t'(POSITIONS - 1);
	localparam int     CYCLE_LIMIT = 500000;
	localparam int     TAIL_CYCLES = 64;
	localparam int     MAX_GAP     = 13;
	localparam int     PRINT_CAP   = 50;

	// One query waiting for its total
	typedef struct {
		idx_t pos;
		cnt_t total;
	} pending_query_t;

	logic clk;
	logic arst_n;

	stra_cmd_if cmd_bus();
	stra_rsp_if rsp_bus();

	segment_tree_range_add_point_query_core #(
		.POSITIONS(POSITIONS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// Shadow tree and pending totals
	cnt_t           tree_counts [0:NODES-1];
	pending_query_t pending_totals[$];

	int   err_count;
	int   cycle_count;
	int   rsp_hold_cycles;
	logic cmd_idle_en;
	logic rsp_idle_en;
	idx_t last_add_lo;
	idx_t last_add_hi;

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("segment_tree_range_add_point_query_core_test NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shadow tree: same bottom-up walk as the core, counts wrap at 16 bits
	// ------------------------------------------------------------------
	function automatic void add_over_range(idx_t lo, idx_t hi, cnt_t d);
		int unsigned l;
		int unsigned r;
		l = int'(lo) + POSITIONS;
		r = int'(hi) + POSITIONS + 1;
		while (l < r) begin
			if ((l & 1) != 0) begin
				tree_counts[l] = tree_counts[l] + d;
				l++;
			end
			if ((r & 1) != 0) begin
				r--;
				tree_counts[r] = tree_counts[r] + d;
			end
			l = l >> 1;
			r = r >> 1;
		end
	endfunction

	function automatic cnt_t total_at(idx_t pos);
		int unsigned n;
		cnt_t acc;
		acc = '0;
		if (int'(pos) >= POSITIONS)
			return acc;
		n = int'(pos) + POSITIONS;
		while (n > 0) begin
			acc = acc + tree_counts[n];
			n = n >> 1;
		end
		return acc;
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input idx_t pos,
		input cnt_t got, input cnt_t want);
		if (err_count < PRINT_CAP)
			$display("ERROR at %0t: %s, position %0d: got %0d, want %0d",
				$realtime, what, pos, got, want);
		err_count++;
	endtask

	// ------------------------------------------------------------------
	// Command sender: random gap, then hold the beat until it is taken
	// ------------------------------------------------------------------
	task automatic send_command(input logic fn, input idx_t lo, input idx_t hi,
		input cnt_t d);
		int gap;
		pending_query_t q;
		gap = cmd_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		repeat (gap) begin
			@(negedge clk);
			cmd_bus.valid      = 1'b0;
			cmd_bus.func       = logic'($urandom);
			cmd_bus.low_index  = idx_t'($urandom);
			cmd_bus.high_index = idx_t'($urandom);
			cmd_bus.delta      = cnt_t'($urandom);
		end
		@(negedge clk);
		cmd_bus.valid      = 1'b1;
		cmd_bus.func       = fn;
		cmd_bus.low_index  = lo;
		cmd_bus.high_index = hi;
		cmd_bus.delta      = d;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		// beat taken: update the shadow tree or queue the total
		if (fn == FN_ADD) begin
			if (lo <= hi && int'(hi) < POSITIONS)
				add_over_range(lo, hi, d);
		end else begin
			q.pos   = lo;
			q.total = total_at(lo);
			pending_totals.push_back(q);
		end
	endtask

	task automatic release_cmd();
		@(negedge clk);
		cmd_bus.valid = 1'b0;
	endtask

	task automatic wait_for_drain();
		while (pending_totals.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result receiver: long hold-off first, then per-beat random gap
	// ------------------------------------------------------------------
	initial begin : rsp_receiver
		int gap;
		gap = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_bus.ready = 1'b0;
				rsp_hold_cycles--;
			end else if (gap > 0) begin
				rsp_bus.ready = 1'b0;
				gap--;
			end else begin
				rsp_bus.ready = 1'b1;
			end
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready)
				gap = rsp_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	// Result checker: each total against the oldest pending query
	always @(posedge clk) begin
		pending_query_t q;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_totals.size() == 0) begin
				report_mismatch("result beat with no query pending", '0,
					rsp_bus.point_total, '0);
			end else begin
				q = pending_totals.pop_front();
				if (rsp_bus.point_total !== q.total)
					report_mismatch("point_total", q.pos, rsp_bus.point_total, q.total);
			end
		end
	end

	// ------------------------------------------------------------------
	// Random item with shaped ranges and deltas
	// ------------------------------------------------------------------
	task automatic send_random_command();
		logic fn;
		idx_t lo;
		idx_t hi;
		idx_t t;
		cnt_t d;
		int   pick;
		fn = ($urandom_range(0, 99) < 45) ? FN_QUERY : FN_ADD;
		lo = idx_t'($urandom);
		hi = idx_t'($urandom);
		d  = cnt_t'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 4))
				0: d = 16'sh7FFF;
				1: d = 16'sh8000;
				2: d = 16'shFFFF;
				3: d = 16'sh0000;
				default: d = 16'sh0001;
			endcase
		end
		if (fn == FN_ADD) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: hi = lo;
				1: begin
					// reversed range, must change nothing
					if (lo == hi)
						hi = lo ^ idx_t'(1);
					if (lo < hi) begin
						t  = lo;
						lo = hi;
						hi = t;
					end
				end
				2: begin
					if ($urandom_range(0, 1) != 0)
						lo = '0;
					else
						hi = IDX_MAX;
				end
				3, 4, 5: hi = (lo > IDX_MAX - 15) ? IDX_MAX : lo + idx_t'($urandom_range(0, 15));
				default: ;
			endcase
			if (pick != 1 && lo > hi) begin
				t  = lo;
				lo = hi;
				hi = t;
			end
			if (pick != 1) begin
				last_add_lo = lo;
				last_add_hi = hi;
			end
		end else if ($urandom_range(0, 2) == 0) begin
			// probe just at or beside the edges of the last range
			lo = ($urandom_range(0, 1) != 0) ? last_add_lo : last_add_hi;
			case ($urandom_range(0, 2))
				0: if (lo != '0) lo = lo - idx_t'(1);
				1: if (lo != IDX_MAX) lo = lo + idx_t'(1);
				default: ;
			endcase
		end
		send_command(fn, lo, hi, d);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		cmd_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
		// cleared tree reads zero at both ends
		send_command(FN_QUERY, '0, IDX_MAX, 16'sh7FFF);
		send_command(FN_QUERY, IDX_MAX, '0, 16'sh8000);
		// full range, single leaves at both ends
		send_command(FN_ADD, '0, IDX_MAX, 16'sh7FFF);
		send_command(FN_ADD, '0, '0, 16'sh8000);
		send_command(FN_ADD, IDX_MAX, IDX_MAX, 16'sh0001);
		// reversed ranges leave the tree alone
		send_command(FN_ADD, 10'd5, 10'd3, 16'sh1234);
		send_command(FN_ADD, IDX_MAX, '0, 16'sh7FFF);
		send_command(FN_QUERY, '0, '0, '0);
		send_command(FN_QUERY, IDX_MAX, IDX_MAX, '0);
		send_command(FN_QUERY, 10'd4, 10'd0, '0);
		// wrap past the positive limit
		send_command(FN_ADD, 10'd1, 10'd1022, 16'sh7FFF);
		send_command(FN_QUERY, 10'd512, 10'h3FF, 16'shFFFF);
		// single leaf in the middle, and its neighbors
		send_command(FN_ADD, 10'd512, 10'd512, 16'shFFFF);
		send_command(FN_QUERY, 10'd511, '0, '0);
		send_command(FN_QUERY, 10'd512, '0, '0);
		send_command(FN_QUERY, 10'd513, '0, '0);
		// uneven ranges that split at many levels
		send_command(FN_ADD, 10'd1, 10'd1022, 16'sh8000);
		send_command(FN_ADD, 10'd341, 10'd682, 16'sh5555);
		send_command(FN_ADD, 10'd0, 10'd1022, 16'shAAAA);
		send_command(FN_QUERY, 10'd340, '0, '0);
		send_command(FN_QUERY, 10'd341, '0, '0);
		send_command(FN_QUERY, 10'd682, '0, '0);
		send_command(FN_QUERY, 10'd1022, '0, '0);
		send_command(FN_QUERY, IDX_MAX, '0, '0);
		last_add_lo = 10'd341;
		last_add_hi = 10'd682;
	endtask

	task automatic test_random_phase(input logic cmd_idle, input logic rsp_idle,
		input int count);
		cmd_idle_en = cmd_idle;
		rsp_idle_en = rsp_idle;
		repeat (count)
			send_random_command();
	endtask

	// Receiver holds off while the sender keeps offering beats
	task automatic test_result_stall();
		cmd_idle_en = 1'b0;
		rsp_idle_en = 1'b0;
		rsp_hold_cycles = 300;
		repeat (12) begin
			send_command(FN_QUERY, idx_t'($urandom), idx_t'($urandom), cnt_t'($urandom));
			send_random_command();
		end
		release_cmd();
		wait_for_drain();
	endtask

	// Sender stops until every total is back, several times over
	task automatic test_drain_pause();
		cmd_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
		repeat (5) begin
			repeat (15)
				send_random_command();
			release_cmd();
			wait_for_drain();
		end
	endtask

	task automatic finish_run();
		release_cmd();
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_totals.size() == 0)
			$display("segment_tree_range_add_point_query_core_test OK");
		else
			$display("segment_tree_range_add_point_query_core_test NOT OK");
		$finish;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		cmd_bus.valid      = 1'b0;
		cmd_bus.func       = FN_ADD;
		cmd_bus.low_index  = '0;
		cmd_bus.high_index = '0;
		cmd_bus.delta      = '0;
		err_count          = 0;
		cycle_count        = 0;
		rsp_hold_cycles    = 0;
		cmd_idle_en        = 1'b1;
		rsp_idle_en        = 1'b1;
		last_add_lo        = '0;
		last_add_hi        = IDX_MAX;
		foreach (tree_counts[i])
			tree_counts[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(1'b1, 1'b1, 200);
		test_result_stall();
		test_random_phase(1'b0, 1'b0, 200);
		test_random_phase(1'b1, 1'b0, 200);
		test_drain_pause();
		test_random_phase(1'b0, 1'b1, 200);
		finish_run();
	end

endmodule
